[sv/tse_pkg.sv]
// Package for the topological sort engine.
// Holds the item and result types, the sequencer states and the size constants.
// No dependencies.
package tse_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int NODE_W    = 6;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int NODE_CW   = NODE_AW + 1;
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int EDGE_CW   = EDGE_AW + 1;
    localparam int ADDS_W    = 7;
    localparam int ADDS_MAX  = 127;

    localparam logic [1:0] ACT_ADD_NODE = 2'd0;
    localparam logic [1:0] ACT_ADD_EDGE = 2'd1;
    localparam logic [1:0] ACT_RUN      = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] node_id;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] order_node;
        logic              is_last;
        logic              cycle_found;
        logic              graph_empty;
        logic              edge_overflow;
    } result_t;

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } edge_t;

    typedef struct packed {
        logic                 start;
        logic [MAX_NODES-1:0] present;
        logic [ADDS_W-1:0]    adds;
        logic [EDGE_CW-1:0]   edge_total;
        logic                 overflow;
    } graph_info_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sort_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR_DEG,
        ST_DEG_RD,
        ST_DEG_WAIT,
        ST_DEG_UPD,
        ST_PUSH0,
        ST_PUSH0_CHK,
        ST_POP,
        ST_POP_WAIT,
        ST_HCLR,
        ST_HIT_RD,
        ST_HIT_WAIT,
        ST_HIT_UPD,
        ST_DEC_RD,
        ST_DEC_CHK,
        ST_FINISH,
        ST_EMIT_EMPTY,
        ST_EMIT_CYC,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_DONE
    } sort_state_t;

endpackage

[sv/topological_sort_engine.sv]
// Top level of the topological sort engine: input transfer, node store and load counters.
// Depends on tse_pkg, tse_edge_ram and tse_sorter.
//
// Load items (add node, add edge) are taken when item_stall is low and give no result. A run
// item holds item_stall high until its last result has been written to the output register
// and the store has been cleared in the cycle after. The steps are: start, clear the
// in-degree table, then scan the stored edges to build in-degrees, with a read-modify-write
// for each live edge. Seeding the ready stack checks each node id, reads the in-degree of
// each present node, and finishes. Each popped node is popped, clears the hit table, runs
// the same edge scan, and applies its hits. Then come a finish step and the emission of each
// node, plus any stall of the result side. The walk is bound by the single read port of the
// edge store, which is scanned once per popped node. The run clears the node and edge store.
module topological_sort_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  tse_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output tse_pkg::result_t result
);

    localparam int EC = tse_pkg::EDGE_CW;

    logic [tse_pkg::MAX_NODES-1:0] present_reg, present_next;
    logic [tse_pkg::ADDS_W-1:0]    adds_reg, adds_next;
    logic [EC-1:0]                 total_reg, total_next;
    logic                          ovf_reg, ovf_next;
    logic                          accept;
    logic                          edge_wr;
    logic                          edge_rd_en;
    logic [tse_pkg::EDGE_AW-1:0]   edge_rd_addr;
    tse_pkg::edge_t                edge_wr_data, edge_rd;
    tse_pkg::graph_info_t          info;
    tse_pkg::sort_status_t         status;

    assign item_stall = status.busy;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            adds_reg    <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            adds_reg    <= adds_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_comb
    begin
        present_next = present_reg;
        adds_next    = adds_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        edge_wr      = 1'b0;
        if (status.done)
        begin
            present_next = '0;
            adds_next    = '0;
            total_next   = '0;
            ovf_next     = 1'b0;
        end
        else if (accept && item.action == tse_pkg::ACT_ADD_NODE)
        begin
            present_next[item.node_id] = 1'b1;
            if (adds_reg != tse_pkg::ADDS_W'(tse_pkg::ADDS_MAX))
            begin
                adds_next = adds_reg + tse_pkg::ADDS_W'(1);
            end
        end
        else if (accept && item.action == tse_pkg::ACT_ADD_EDGE)
        begin
            if (total_reg < EC'(tse_pkg::MAX_EDGES))
            begin
                edge_wr    = 1'b1;
                total_next = total_reg + EC'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    assign edge_wr_data.src = item.from_node;
    assign edge_wr_data.dst = item.to_node;

    assign info.start      = accept && item.action == tse_pkg::ACT_RUN;
    assign info.present    = present_reg;
    assign info.adds       = adds_reg;
    assign info.edge_total = total_reg;
    assign info.overflow   = ovf_reg;

    tse_edge_ram u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr),
        .wr_addr (total_reg[tse_pkg::EDGE_AW-1:0]),
        .wr_data (edge_wr_data),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd)
    );

    tse_sorter u_sorter (
        .clk          (clk),
        .rst_n        (rst_n),
        .info         (info),
        .status       (status),
        .edge_rd_en   (edge_rd_en),
        .edge_rd_addr (edge_rd_addr),
        .edge_rd      (edge_rd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[sv/tse_edge_ram.sv]
// Edge store of the topological sort engine: one write port, one registered read port.
// Depends on tse_pkg.
module tse_edge_ram (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [tse_pkg::EDGE_AW-1:0] wr_addr,
    input  tse_pkg::edge_t              wr_data,
    input  logic                        rd_en,
    input  logic [tse_pkg::EDGE_AW-1:0] rd_addr,
    output tse_pkg::edge_t              rd_data
);

    tse_pkg::edge_t mem [tse_pkg::MAX_EDGES];
    tse_pkg::edge_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/tse_sorter.sv]
// Graph walk sequencer: in-degree build, ready stack, per-node hit count and result output.
// One shared add/subtract unit serves every in-degree and hit count update. Depends on tse_pkg.
module tse_sorter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tse_pkg::graph_info_t        info,
    output tse_pkg::sort_status_t       status,
    output logic                        edge_rd_en,
    output logic [tse_pkg::EDGE_AW-1:0] edge_rd_addr,
    input  tse_pkg::edge_t              edge_rd,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tse_pkg::result_t            result
);

    localparam int NA = tse_pkg::NODE_AW;
    localparam int NC = tse_pkg::NODE_CW;
    localparam int EC = tse_pkg::EDGE_CW;

    tse_pkg::sort_state_t state_reg, state_next;
    logic [NC-1:0]  idx_reg, idx_next;
    logic [EC-1:0]  e_reg, e_next;
    logic [NC-1:0]  top_reg, top_next;
    logic [NC-1:0]  count_reg, count_next;
    logic [NA-1:0]  u_reg, u_next;
    logic [NA-1:0]  tgt_reg, tgt_next;
    logic           out_valid_reg, out_valid_next;
    tse_pkg::result_t out_reg, out_next;

    logic [EC-1:0] deg_mem [tse_pkg::MAX_NODES];
    logic [EC-1:0] hit_mem [tse_pkg::MAX_NODES];
    logic [NA-1:0] stk_mem [tse_pkg::MAX_NODES];
    logic [NA-1:0] ord_mem [tse_pkg::MAX_NODES];
    logic [EC-1:0] deg_rd_reg, hit_rd_reg;
    logic [NA-1:0] stk_rd_reg, ord_rd_reg;

    logic          deg_we, hit_we, stk_we, ord_we;
    logic          deg_re, hit_re, stk_re, ord_re;
    logic [NA-1:0] deg_wa, hit_wa, stk_wa, ord_wa;
    logic [NA-1:0] deg_ra, hit_ra, stk_ra, ord_ra;
    logic [EC-1:0] deg_wd, hit_wd;
    logic [NA-1:0] stk_wd, ord_wd;

    logic [EC-1:0] alu_a, alu_b, alu_y;
    logic          alu_sub;
    logic          out_free;
    logic          live;

    assign alu_y    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign out_free = !out_valid_reg || !result_stall;
    assign live     = info.present[edge_rd.src] && info.present[edge_rd.dst];

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_wa] <= deg_wd;
        end
        if (deg_re)
        begin
            deg_rd_reg <= deg_mem[deg_ra];
        end
        if (hit_we)
        begin
            hit_mem[hit_wa] <= hit_wd;
        end
        if (hit_re)
        begin
            hit_rd_reg <= hit_mem[hit_ra];
        end
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
        if (ord_we)
        begin
            ord_mem[ord_wa] <= ord_wd;
        end
        if (ord_re)
        begin
            ord_rd_reg <= ord_mem[ord_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tse_pkg::ST_IDLE;
            idx_reg       <= '0;
            e_reg         <= '0;
            top_reg       <= '0;
            count_reg     <= '0;
            u_reg         <= '0;
            tgt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            e_reg         <= e_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            u_reg         <= u_next;
            tgt_reg       <= tgt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        e_next         = e_reg;
        top_next       = top_reg;
        count_next     = count_reg;
        u_next         = u_reg;
        tgt_next       = tgt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        status.busy    = (state_reg != tse_pkg::ST_IDLE);
        status.done    = 1'b0;
        edge_rd_en     = 1'b0;
        edge_rd_addr   = e_reg[tse_pkg::EDGE_AW-1:0];
        deg_we = 1'b0; deg_re = 1'b0; deg_wa = idx_reg[NA-1:0];
        deg_ra = idx_reg[NA-1:0]; deg_wd = '0;
        hit_we = 1'b0; hit_re = 1'b0; hit_wa = idx_reg[NA-1:0];
        hit_ra = idx_reg[NA-1:0]; hit_wd = '0;
        stk_we = 1'b0; stk_re = 1'b0; stk_wa = top_reg[NA-1:0];
        stk_ra = top_reg[NA-1:0]; stk_wd = idx_reg[NA-1:0];
        ord_we = 1'b0; ord_re = 1'b0; ord_wa = count_reg[NA-1:0];
        ord_ra = idx_reg[NA-1:0]; ord_wd = stk_rd_reg;
        alu_a   = '0;
        alu_b   = EC'(1);
        alu_sub = 1'b0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tse_pkg::ST_IDLE:
            begin
                if (info.start)
                begin
                    idx_next   = '0;
                    e_next     = '0;
                    top_next   = '0;
                    count_next = '0;
                    state_next = (info.adds == '0) ? tse_pkg::ST_EMIT_EMPTY
                                                   : tse_pkg::ST_CLR_DEG;
                end
            end
            tse_pkg::ST_CLR_DEG:
            begin
                deg_we = 1'b1;
                if (idx_reg == NC'(tse_pkg::MAX_NODES - 1))
                begin
                    e_next     = '0;
                    state_next = tse_pkg::ST_DEG_RD;
                end
                else
                begin
                    idx_next = idx_reg + NC'(1);
                end
            end
            tse_pkg::ST_DEG_RD:
            begin
                if (e_reg == info.edge_total)
                begin
                    idx_next   = '0;
                    state_next = tse_pkg::ST_PUSH0;
                end
                else
                begin
                    edge_rd_en = 1'b1;
                    state_next = tse_pkg::ST_DEG_WAIT;
                end
            end
            tse_pkg::ST_DEG_WAIT:
            begin
                if (live)
                begin
                    deg_re     = 1'b1;
                    deg_ra     = edge_rd.dst;
                    tgt_next   = edge_rd.dst;
                    state_next = tse_pkg::ST_DEG_UPD;
                end
                else
                begin
                    e_next     = e_reg + EC'(1);
                    state_next = tse_pkg::ST_DEG_RD;
                end
            end
            tse_pkg::ST_DEG_UPD:
            begin
                alu_a      = deg_rd_reg;
                deg_we     = 1'b1;
                deg_wa     = tgt_reg;
                deg_wd     = alu_y;
                e_next     = e_reg + EC'(1);
                state_next = tse_pkg::ST_DEG_RD;
            end
            tse_pkg::ST_PUSH0:
            begin
                if (idx_reg == NC'(tse_pkg::MAX_NODES))
                begin
                    state_next = tse_pkg::ST_POP;
                end
                else if (info.present[idx_reg[NA-1:0]])
                begin
                    deg_re     = 1'b1;
                    state_next = tse_pkg::ST_PUSH0_CHK;
                end
                else
                begin
                    idx_next = idx_reg + NC'(1);
                end
            end
            tse_pkg::ST_PUSH0_CHK:
            begin
                if (deg_rd_reg == '0 && top_reg < NC'(tse_pkg::MAX_NODES))
                begin
                    stk_we   = 1'b1;
                    top_next = top_reg + NC'(1);
                end
                idx_next   = idx_reg + NC'(1);
                state_next = tse_pkg::ST_PUSH0;
            end
            tse_pkg::ST_POP:
            begin
                if (top_reg == '0)
                begin
                    state_next = tse_pkg::ST_FINISH;
                end
                else
                begin
                    stk_re     = 1'b1;
                    stk_ra     = NA'(top_reg - NC'(1));
                    top_next   = top_reg - NC'(1);
                    state_next = tse_pkg::ST_POP_WAIT;
                end
            end
            tse_pkg::ST_POP_WAIT:
            begin
                u_next = stk_rd_reg;
                if (count_reg < NC'(tse_pkg::MAX_NODES))
                begin
                    ord_we     = 1'b1;
                    count_next = count_reg + NC'(1);
                end
                idx_next   = '0;
                state_next = tse_pkg::ST_HCLR;
            end
            tse_pkg::ST_HCLR:
            begin
                hit_we = 1'b1;
                if (idx_reg == NC'(tse_pkg::MAX_NODES - 1))
                begin
                    e_next     = '0;
                    state_next = tse_pkg::ST_HIT_RD;
                end
                else
                begin
                    idx_next = idx_reg + NC'(1);
                end
            end
            tse_pkg::ST_HIT_RD:
            begin
                if (e_reg == info.edge_total)
                begin
                    idx_next   = '0;
                    state_next = tse_pkg::ST_DEC_RD;
                end
                else
                begin
                    edge_rd_en = 1'b1;
                    state_next = tse_pkg::ST_HIT_WAIT;
                end
            end
            tse_pkg::ST_HIT_WAIT:
            begin
                if (live && edge_rd.src == u_reg)
                begin
                    hit_re     = 1'b1;
                    hit_ra     = edge_rd.dst;
                    tgt_next   = edge_rd.dst;
                    state_next = tse_pkg::ST_HIT_UPD;
                end
                else
                begin
                    e_next     = e_reg + EC'(1);
                    state_next = tse_pkg::ST_HIT_RD;
                end
            end
            tse_pkg::ST_HIT_UPD:
            begin
                alu_a      = hit_rd_reg;
                hit_we     = 1'b1;
                hit_wa     = tgt_reg;
                hit_wd     = alu_y;
                e_next     = e_reg + EC'(1);
                state_next = tse_pkg::ST_HIT_RD;
            end
            tse_pkg::ST_DEC_RD:
            begin
                if (idx_reg == NC'(tse_pkg::MAX_NODES))
                begin
                    state_next = tse_pkg::ST_POP;
                end
                else
                begin
                    deg_re     = 1'b1;
                    hit_re     = 1'b1;
                    state_next = tse_pkg::ST_DEC_CHK;
                end
            end
            tse_pkg::ST_DEC_CHK:
            begin
                alu_a   = deg_rd_reg;
                alu_b   = hit_rd_reg;
                alu_sub = 1'b1;
                if (hit_rd_reg != '0)
                begin
                    deg_we = 1'b1;
                    if (deg_rd_reg <= hit_rd_reg)
                    begin
                        deg_wd = '0;
                        if (top_reg < NC'(tse_pkg::MAX_NODES))
                        begin
                            stk_we   = 1'b1;
                            top_next = top_reg + NC'(1);
                        end
                    end
                    else
                    begin
                        deg_wd = alu_y;
                    end
                end
                idx_next   = idx_reg + NC'(1);
                state_next = tse_pkg::ST_DEC_RD;
            end
            tse_pkg::ST_FINISH:
            begin
                idx_next   = '0;
                state_next = (count_reg != info.adds) ? tse_pkg::ST_EMIT_CYC
                                                      : tse_pkg::ST_OUT_RD;
            end
            tse_pkg::ST_EMIT_EMPTY, tse_pkg::ST_EMIT_CYC:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.order_node    = '0;
                    out_next.is_last       = 1'b1;
                    out_next.cycle_found   = (state_reg == tse_pkg::ST_EMIT_CYC);
                    out_next.graph_empty   = (state_reg == tse_pkg::ST_EMIT_EMPTY);
                    out_next.edge_overflow = info.overflow;
                    state_next             = tse_pkg::ST_DONE;
                end
            end
            tse_pkg::ST_OUT_RD:
            begin
                ord_re     = 1'b1;
                state_next = tse_pkg::ST_OUT_WAIT;
            end
            tse_pkg::ST_OUT_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.order_node    = ord_rd_reg;
                    out_next.is_last       = (idx_reg + NC'(1) == count_reg);
                    out_next.cycle_found   = 1'b0;
                    out_next.graph_empty   = 1'b0;
                    out_next.edge_overflow = info.overflow;
                    if (idx_reg + NC'(1) == count_reg)
                    begin
                        state_next = tse_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + NC'(1);
                        state_next = tse_pkg::ST_OUT_RD;
                    end
                end
            end
            tse_pkg::ST_DONE:
            begin
                status.done = 1'b1;
                state_next  = tse_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tse_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[sv/tse_checker.sv]
// Port checker for the topological sort engine, bound to the top level.
// Depends on tse_pkg and topological_sort_engine.
module tse_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input tse_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input tse_pkg::result_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.action == tse_pkg::ACT_RUN |=> item_stall)
        else $error("run transfer did not hold the input");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.cycle_found || result.graph_empty)
        |-> result.is_last && result.order_node == '0)
        else $error("status result not final or carries a node");

    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.cycle_found && result.graph_empty))
        else $error("cycle and empty both flagged");

endmodule

bind topological_sort_engine tse_checker u_tse_checker (.*);

[sim/topological_sort_engine_checker.sv]
// Checker for the topological sort engine: watches both channels, predicts each run's order.
// Depends on tse_pkg; instantiated beside the block by topological_sort_engine_tb.
`timescale 1ns / 100ps
module topological_sort_engine_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  tse_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  tse_pkg::result_t result,
    output int               mismatches,
    output int               expected_left
);

    logic              present [tse_pkg::MAX_NODES];
    int                node_count;
    tse_pkg::edge_t    edge_store [tse_pkg::MAX_EDGES];
    int                edge_count;
    logic              dropped;
    tse_pkg::result_t  order_q [$];

    initial
    begin
        mismatches = 0;
        for (int i = 0; i < tse_pkg::MAX_NODES; i++)
            present[i] = 1'b0;
        node_count = 0;
        edge_count = 0;
        dropped    = 1'b0;
    end

    assign expected_left = order_q.size();

    task automatic report(input string field, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic logic edge_live(input int e);
        return present[edge_store[e].src] && present[edge_store[e].dst];
    endfunction

    task automatic clear_graph();
        for (int i = 0; i < tse_pkg::MAX_NODES; i++)
            present[i] = 1'b0;
        node_count = 0;
        edge_count = 0;
        dropped    = 1'b0;
    endtask

    task automatic push_result(input int node, input logic last, input logic cyc,
                               input logic empty);
        tse_pkg::result_t r;
        r.order_node    = node[tse_pkg::NODE_W-1:0];
        r.is_last       = last;
        r.cycle_found   = cyc;
        r.graph_empty   = empty;
        r.edge_overflow = dropped;
        order_q.insert(order_q.size(), r);
    endtask

    task automatic sort_graph();
        int deg [tse_pkg::MAX_NODES];
        int hits [tse_pkg::MAX_NODES];
        int stack [tse_pkg::MAX_NODES];
        int order [tse_pkg::MAX_NODES];
        int top;
        int cnt;
        int u;
        top = 0;
        cnt = 0;
        if (node_count == 0)
        begin
            push_result(0, 1'b1, 1'b0, 1'b1);
            clear_graph();
            return;
        end
        for (int v = 0; v < tse_pkg::MAX_NODES; v++)
            deg[v] = 0;
        for (int e = 0; e < edge_count; e++)
            if (edge_live(e))
                deg[edge_store[e].dst]++;
        for (int v = 0; v < tse_pkg::MAX_NODES; v++)
            if (present[v] && deg[v] == 0 && top < tse_pkg::MAX_NODES)
            begin
                stack[top] = v;
                top++;
            end
        while (top > 0)
        begin
            top--;
            u = stack[top];
            if (cnt < tse_pkg::MAX_NODES)
            begin
                order[cnt] = u;
                cnt++;
            end
            for (int v = 0; v < tse_pkg::MAX_NODES; v++)
                hits[v] = 0;
            for (int e = 0; e < edge_count; e++)
                if (edge_store[e].src == u && edge_live(e))
                    hits[edge_store[e].dst]++;
            for (int v = 0; v < tse_pkg::MAX_NODES; v++)
            begin
                if (hits[v] == 0)
                    continue;
                if (deg[v] <= hits[v])
                begin
                    deg[v] = 0;
                    if (top < tse_pkg::MAX_NODES)
                    begin
                        stack[top] = v;
                        top++;
                    end
                end
                else
                    deg[v] -= hits[v];
            end
        end
        if (cnt != node_count)
            push_result(0, 1'b1, 1'b1, 1'b0);
        else
            for (int k = 0; k < cnt; k++)
                push_result(order[k], k + 1 == cnt, 1'b0, 1'b0);
        clear_graph();
    endtask

    task automatic load_item(input tse_pkg::item_t it);
        case (it.action)
            tse_pkg::ACT_ADD_NODE:
            begin
                present[it.node_id] = 1'b1;
                if (node_count < tse_pkg::ADDS_MAX)
                    node_count++;
            end
            tse_pkg::ACT_ADD_EDGE:
            begin
                if (edge_count < tse_pkg::MAX_EDGES)
                begin
                    edge_store[edge_count].src = it.from_node;
                    edge_store[edge_count].dst = it.to_node;
                    edge_count++;
                end
                else
                    dropped = 1'b1;
            end
            tse_pkg::ACT_RUN:
                sort_graph();
            default:
                ;
        endcase
    endtask

    always @(posedge clk)
    begin
        tse_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (order_q.size() == 0)
                    report("unexpected result", int'(result), 0);
                else
                begin
                    want = order_q.pop_front();
                    if (result.order_node != want.order_node)
                        report("order_node", int'(result.order_node),
                               int'(want.order_node));
                    if (result.is_last != want.is_last)
                        report("is_last", int'(result.is_last), int'(want.is_last));
                    if (result.cycle_found != want.cycle_found)
                        report("cycle_found", int'(result.cycle_found),
                               int'(want.cycle_found));
                    if (result.graph_empty != want.graph_empty)
                        report("graph_empty", int'(result.graph_empty),
                               int'(want.graph_empty));
                    if (result.edge_overflow != want.edge_overflow)
                        report("edge_overflow", int'(result.edge_overflow),
                               int'(want.edge_overflow));
                end
            end
            if (item_valid && !item_stall)
                load_item(item);
        end
    end
endmodule

[sim/topological_sort_engine_tb.sv]
// Testbench top for the topological sort engine: clock, reset, stimulus and verdict.
// Depends on tse_pkg, topological_sort_engine and topological_sort_engine_checker.
`timescale 1ns / 100ps
module topological_sort_engine_tb;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    tse_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    tse_pkg::result_t result;
    int               mismatches;
    int               expected_left;
    int               cycles = 0;
    logic             quiet = 1'b0;
    logic             hold_req = 1'b0;
    logic             started = 1'b0;
    int               sent = 0;
    tse_pkg::item_t   batch [$];

    always #2 clk = ~clk;

    topological_sort_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    topological_sort_engine_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (quiet || r < 10)
            return 0;
        if (r < 19)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        int r;
        int n;
        @(posedge clk);
        while (!started)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_stall <= 1'b0;
                do
                    @(posedge clk);
                while (!result_valid);
                result_stall <= 1'b1;
                for (int c = 0; c < 3000; c++)
                    @(posedge clk);
                hold_req <= 1'b0;
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 9);
                n = pick_gap();
                if (quiet || r < 5 || n == 0)
                begin
                    result_stall <= 1'b0;
                    @(posedge clk);
                end
                else
                begin
                    result_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    function automatic tse_pkg::item_t make_item(input logic [1:0] act, input int id,
                                                 input int src, input int dst);
        tse_pkg::item_t it;
        it = tse_pkg::item_t'($urandom);
        it.action = act;
        if (act == tse_pkg::ACT_ADD_NODE)
            it.node_id = id[tse_pkg::NODE_W-1:0];
        if (act == tse_pkg::ACT_ADD_EDGE)
        begin
            it.from_node = src[tse_pkg::NODE_W-1:0];
            it.to_node   = dst[tse_pkg::NODE_W-1:0];
        end
        return it;
    endfunction

    task automatic add_to_batch(input tse_pkg::item_t it);
        batch.insert(batch.size(), it);
    endtask

    task automatic send(input tse_pkg::item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        sent++;
    endtask

    task automatic send_batch();
        while (batch.size() > 0)
            send(batch.pop_front());
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (200) @(posedge clk);
    endtask

    // Random graph: mostly forward edges over a random order, some back and dangling edges.
    task automatic build_graph(input int n, input int m, input int back_pct);
        int   ids [$];
        logic used [tse_pkg::MAX_NODES];
        int   v;
        int   i;
        int   j;
        int   r;
        tse_pkg::item_t tmp;
        for (int k = 0; k < tse_pkg::MAX_NODES; k++)
            used[k] = 1'b0;
        while (ids.size() < n)
        begin
            v = $urandom_range(0, tse_pkg::MAX_NODES - 1);
            if (!used[v])
            begin
                used[v] = 1'b1;
                ids.insert(ids.size(), v);
            end
        end
        foreach (ids[k])
            add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, ids[k], 0, 0));
        if ($urandom_range(0, 7) == 0)
            add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, ids[$urandom_range(0, n - 1)],
                                   0, 0));
        for (int k = 0; k < m && n > 1; k++)
        begin
            i = $urandom_range(0, n - 2);
            j = $urandom_range(i + 1, n - 1);
            r = $urandom_range(0, 99);
            if (r < back_pct)
                add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, ids[j], ids[i]));
            else if (r < back_pct + 8)
                add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, ids[i],
                                       $urandom_range(0, tse_pkg::MAX_NODES - 1)));
            else
                add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, ids[i], ids[j]));
        end
        if ($urandom_range(0, 4) == 0)
            add_to_batch(make_item(ACT_UNUSED, 0, 0, 0));
        for (int k = batch.size() - 1; k > 0; k--)
        begin
            r = $urandom_range(0, k);
            tmp = batch[k];
            batch[k] = batch[r];
            batch[r] = tmp;
        end
        add_to_batch(make_item(tse_pkg::ACT_RUN, 0, 0, 0));
    endtask

    initial
    begin
        int phase;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        started <= 1'b1;

        add_to_batch(make_item(tse_pkg::ACT_RUN, 0, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 0, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 63, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 63, 0));
        add_to_batch(make_item(tse_pkg::ACT_RUN, 0, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 5, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 9, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 7, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 5, 9));
        add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 9, 7));
        add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 5, 7));
        add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 5, 7));
        add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 7, 40));
        add_to_batch(make_item(ACT_UNUSED, 0, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_RUN, 0, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 12, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 12, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_RUN, 0, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 1, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 2, 0, 0));
        add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 1, 2));
        add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 2, 1));
        add_to_batch(make_item(tse_pkg::ACT_RUN, 0, 0, 0));
        send_batch();

        phase = 0;
        while (sent < 130)
        begin
            quiet <= (phase % 5 == 3);
            build_graph($urandom_range(1, 8), $urandom_range(0, 12), 10);
            send_batch();
            if (phase == 4)
                drain();
            phase++;
        end
        quiet <= 1'b0;

        // Fill the edge store past capacity over a small node set.
        for (int k = 0; k < 3; k++)
            add_to_batch(make_item(tse_pkg::ACT_ADD_NODE, 20 + k, 0, 0));
        for (int k = 0; k < tse_pkg::MAX_EDGES + 4; k++)
            add_to_batch(make_item(tse_pkg::ACT_ADD_EDGE, 0, 20 + (k % 2), 22));
        add_to_batch(make_item(tse_pkg::ACT_RUN, 0, 0, 0));
        send_batch();

        // Every node present; hold the result side while the next graph queues up.
        build_graph(tse_pkg::MAX_NODES, 20, 0);
        hold_req <= 1'b1;
        send_batch();
        for (int k = 0; k < 6; k++)
        begin
            build_graph($urandom_range(1, 6), $urandom_range(0, 8), 15);
            send_batch();
        end

        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (500) @(posedge clk);
        if (mismatches == 0 && expected_left == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[filelist.f]
sv/tse_pkg.sv
sv/tse_edge_ram.sv
sv/tse_sorter.sv
sv/topological_sort_engine.sv
sv/tse_checker.sv
sim/topological_sort_engine_checker.sv
sim/topological_sort_engine_tb.sv
